>>> hw/rtl/isb_pkg.sv
// ----------------------------------------------------------------------------
// isb_pkg: shared types and codes for the indexed sequence buffer
// Request and response beat layouts, request selectors and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package isb_pkg;

   // request selectors
   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [2:0] REQ_REMOVE     = 3'd2;
   localparam logic [2:0] REQ_READ       = 3'd3;
   localparam logic [2:0] REQ_WRITE      = 3'd4;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam int DATA_W = 32;
   localparam int POS_W  = 6;
   localparam int CNT_W  = 7;

   typedef struct packed {
      logic [2:0]              req_type;
      logic [POS_W-1:0]        position;
      logic signed [DATA_W-1:0] data_in;
   } isb_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      logic [CNT_W-1:0]        count;
      logic [1:0]              status;
   } isb_rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/indexed_sequence_buffer_core.sv
// ----------------------------------------------------------------------------
// indexed_sequence_buffer_core: bounded double-ended list with indexed access
// Circular store in one RAM with a head pointer and an occupancy count.
// ----------------------------------------------------------------------------
// Each request beat returns exactly one response beat. Push front, push back,
// write, unknown selectors and every rejected request are answered from the
// idle state; a read passes through the read state because the entry RAM
// registers its read data; a remove runs through the shift state, since the
// entries behind the removed one move down one place per cycle through the
// single read and single write port of the RAM. A new request is taken once
// the previous one has finished and the response register is free or being
// drained in the same cycle. The store needs no clearing after reset: only
// entries below the occupancy are ever read.
`default_nettype none

module indexed_sequence_buffer_core #(
   parameter int CAPACITY = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire isb_pkg::isb_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output isb_pkg::isb_rsp_type      rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = CW + 1;
   localparam int PW = (isb_pkg::POS_W > CW) ? isb_pkg::POS_W : CW;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   logic [1:0]    state_ff,  state_in;
   logic [AW-1:0] head_ff,   head_in;
   logic [CW-1:0] occ_ff,    occ_in;
   logic [CW-1:0] src_ff,    src_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   logic          wr_vld_ff, wr_vld_in;
   logic          rsp_valid_ff, rsp_valid_in;
   isb_pkg::isb_rsp_type rsp_ff, rsp_in;

   logic          accept;
   logic          full;
   logic          pos_ok;
   logic [CW-1:0] pos_l;
   logic [AW-1:0] head_dec;
   logic          shift_done;

   logic                          mem_wr_en;
   logic [AW-1:0]                 mem_wr_addr;
   logic [isb_pkg::DATA_W-1:0]    mem_wr_data;
   logic                          mem_rd_en;
   logic [AW-1:0]                 mem_rd_addr;
   logic [isb_pkg::DATA_W-1:0]    mem_rd_data;

   // map a logical position onto a RAM address around the head
   function automatic logic [AW-1:0] log_to_phys(input logic [AW-1:0] head,
                                                 input logic [CW-1:0] idx);
      logic [SW-1:0] sum;
      sum = SW'(head) + SW'(idx);
      if (sum >= SW'(CAPACITY)) begin
         sum = sum - SW'(CAPACITY);
      end
      return AW'(sum);
   endfunction

   // decode request conditions
   assign accept     = req_valid && req_ready;
   assign full       = (occ_ff == CW'(CAPACITY));
   assign pos_ok     = PW'(req_data.position) < PW'(occ_ff);
   assign pos_l      = CW'(PW'(req_data.position));
   assign head_dec   = (head_ff == '0) ? AW'(CAPACITY - 1) : head_ff - AW'(1);
   assign shift_done = (src_ff >= occ_ff);

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);

   // entry store
   isb_ram #(
      .WIDTH (isb_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // sequence requests, drive the RAM ports and build the response
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      src_in       = src_ff;
      wr_idx_in    = wr_idx_ff;
      wr_vld_in    = wr_vld_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = log_to_phys(head_ff, occ_ff);
      mem_wr_data  = req_data.data_in;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = log_to_phys(head_ff, pos_l);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in.data_out = '0;
               rsp_in.status   = isb_pkg::ST_OK;
               rsp_in.count    = isb_pkg::CNT_W'(occ_ff);
               rsp_valid_in    = 1'b1;
               case (req_data.req_type)
                  isb_pkg::REQ_PUSH_FRONT: begin
                     if (full) begin
                        rsp_in.status = isb_pkg::ST_FULL;
                     end else begin
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = head_dec;
                        head_in      = head_dec;
                        occ_in       = occ_ff + CW'(1);
                        rsp_in.count = isb_pkg::CNT_W'(occ_in);
                     end
                  end
                  isb_pkg::REQ_PUSH_BACK: begin
                     if (full) begin
                        rsp_in.status = isb_pkg::ST_FULL;
                     end else begin
                        mem_wr_en    = 1'b1;
                        occ_in       = occ_ff + CW'(1);
                        rsp_in.count = isb_pkg::CNT_W'(occ_in);
                     end
                  end
                  isb_pkg::REQ_REMOVE: begin
                     if (!pos_ok) begin
                        rsp_in.status = isb_pkg::ST_RANGE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        src_in       = pos_l + CW'(1);
                        wr_vld_in    = 1'b0;
                        state_in     = S_SHIFT;
                     end
                  end
                  isb_pkg::REQ_READ: begin
                     if (!pos_ok) begin
                        rsp_in.status = isb_pkg::ST_RANGE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        mem_rd_en    = 1'b1;
                        state_in     = S_READ;
                     end
                  end
                  isb_pkg::REQ_WRITE: begin
                     if (!pos_ok) begin
                        rsp_in.status = isb_pkg::ST_RANGE;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = log_to_phys(head_ff, pos_l);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_in.data_out = mem_rd_data;
            rsp_in.status   = isb_pkg::ST_OK;
            rsp_in.count    = isb_pkg::CNT_W'(occ_ff);
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end
         S_SHIFT: begin
            // retire the entry fetched last cycle one place down
            if (wr_vld_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = log_to_phys(head_ff, wr_idx_ff);
               mem_wr_data = mem_rd_data;
            end
            if (shift_done) begin
               wr_vld_in       = 1'b0;
               occ_in          = occ_ff - CW'(1);
               rsp_in.data_out = '0;
               rsp_in.status   = isb_pkg::ST_OK;
               rsp_in.count    = isb_pkg::CNT_W'(occ_in);
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else begin
               // fetch the next entry behind the gap
               mem_rd_en   = 1'b1;
               mem_rd_addr = log_to_phys(head_ff, src_ff);
               wr_vld_in   = 1'b1;
               wr_idx_in   = src_ff - CW'(1);
               src_in      = src_ff + CW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         wr_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         wr_vld_ff    <= wr_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      wr_idx_ff <= wr_idx_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // occupancy never exceeds the store
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(CAPACITY))
      else $error("occupancy above capacity");

   // a full status is only reported on a full store
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == isb_pkg::ST_FULL
         |-> rsp_ff.count == isb_pkg::CNT_W'(CAPACITY))
      else $error("full status with free room");

   // an accepted good read lands in the read state
   a_read_seq: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.req_type == isb_pkg::REQ_READ && pos_ok
         |=> state_ff == S_READ && !rsp_valid_ff)
      else $error("read did not enter read state");

   // the shift never fetches past the occupancy
   a_shift_src: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> src_ff <= occ_ff && src_ff != '0)
      else $error("shift source out of range");

   // no request is taken while an undelivered response would be lost
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_valid_ff || rsp_ready)
      else $error("response overrun");

endmodule

`default_nettype wire

>>> hw/rtl/isb_ram.sv
// ----------------------------------------------------------------------------
// isb_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module isb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
